>>> src/gcsp_pkg.sv
// Shared types, codes and tables of the granule container stream parser.
`timescale 1ns / 1ps
`default_nettype none
package gcsp_pkg;

	localparam int unsigned MaxResults  = 3;
	localparam int unsigned QueueDepth  = 8;
	localparam int unsigned QueueAw     = $clog2(QueueDepth);
	localparam int unsigned StallLevel  = QueueDepth - MaxResults;
	localparam int unsigned CfgIndexW   = 2;

	localparam logic [15:0] MaxBandCountRst    = 16'd64;
	localparam logic [31:0] MaxPixelsPerBandRst = 32'd200000000;

	localparam logic [CfgIndexW-1:0] CFG_MAX_BAND_COUNT = CfgIndexW'(0);
	localparam logic [CfgIndexW-1:0] CFG_MAX_PIXELS     = CfgIndexW'(1);

	localparam logic [2:0] IT_HEADER = 3'd0;
	localparam logic [2:0] IT_BAND   = 3'd1;
	localparam logic [2:0] IT_STRING = 3'd2;
	localparam logic [2:0] IT_PIXEL  = 3'd3;
	localparam logic [2:0] IT_RANGE  = 3'd4;
	localparam logic [2:0] IT_DONE   = 3'd5;
	localparam logic [2:0] IT_ERROR  = 3'd6;

	localparam logic [2:0] ERR_SIGNATURE = 3'd1;
	localparam logic [2:0] ERR_VERSION   = 3'd2;
	localparam logic [2:0] ERR_HDR_SHORT = 3'd3;
	localparam logic [2:0] ERR_BAND_CNT  = 3'd4;
	localparam logic [2:0] ERR_REC_SHORT = 3'd5;
	localparam logic [2:0] ERR_DIMS      = 3'd6;
	localparam logic [2:0] ERR_DATA_SHORT = 3'd7;

	localparam int unsigned HdrSteps  = 17;
	localparam int unsigned BandSteps = 10;
	localparam logic [7:0]  NoField   = 8'hFF;

	localparam logic [4:0] HDR_STEP_VERSION  = 5'd0;
	localparam logic [4:0] HDR_STEP_RESERVED = 5'd1;
	localparam logic [4:0] HDR_STEP_BANDS    = 5'd15;
	localparam logic [4:0] HDR_STEP_LAST     = 5'd16;
	localparam logic [4:0] BAND_STEP_NAMELEN = 5'd1;
	localparam logic [4:0] BAND_STEP_UNITLEN = 5'd4;
	localparam logic [4:0] BAND_STEP_FILL    = 5'd7;
	localparam logic [4:0] BAND_STEP_WIDTH   = 5'd8;
	localparam logic [4:0] BAND_STEP_HEIGHT  = 5'd9;

	typedef struct packed {
		logic [2:0]  item_type;
		logic [4:0]  field_id;
		logic [15:0] band_index;
		logic [63:0] field_value;
		logic        pixel_valid;
		logic [2:0]  error_code;
		logic        last_of_run;
	} result_t;

	function automatic logic [7:0] sig_byte(input logic [1:0] idx);
		logic [7:0] r;
		case (idx)
			2'd0: r = 8'h4D;
			2'd1: r = 8'h46;
			2'd2: r = 8'h56;
			default: r = 8'h47;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] hdr_size(input logic [4:0] step);
		logic [3:0] r;
		case (step)
			5'd4: r = 4'd2;
			5'd11, 5'd12, 5'd13, 5'd14: r = 4'd8;
			5'd15, 5'd16: r = 4'd2;
			default: r = 4'd1;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] hdr_id(input logic [4:0] step);
		logic [7:0] r;
		case (step)
			5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9: r = 8'(step - 5'd2);
			5'd11, 5'd12, 5'd13, 5'd14, 5'd15: r = 8'(step - 5'd3);
			default: r = NoField;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] band_size(input logic [4:0] step);
		logic [3:0] r;
		case (step)
			5'd0, 5'd7: r = 4'd2;
			5'd2, 5'd8, 5'd9: r = 4'd4;
			5'd5, 5'd6: r = 4'd8;
			default: r = 4'd1;
		endcase
		return r;
	endfunction

	function automatic result_t make_result(input logic [2:0] typ, input logic [4:0] fid,
			input logic [15:0] band, input logic [63:0] val, input logic pv,
			input logic [2:0] err);
		result_t r;
		r.item_type   = typ;
		r.field_id    = fid;
		r.band_index  = band;
		r.field_value = val;
		r.pixel_valid = pv;
		r.error_code  = err;
		r.last_of_run = 1'b0;
		return r;
	endfunction

endpackage
`default_nettype wire

>>> src/granule_container_stream_parser.sv
// Top level: byte-serial container parser with a result queue.
//
// Usage: bytes of a little-endian granule container enter on the byte channel
// (data_byte, end_of_buffer; byte_valid/byte_stall), one byte per cycle unless stalled.
// Each byte yields zero to three result words on the result channel
// (result_valid/result_stall): header and band fields when their last byte
// arrives, string bytes, pixels, band ranges, done and error words.
// An accepted byte's words are registered into the result queue; the first
// one heads the result channel if the queue was empty. Throughput: one byte
// per cycle while each byte makes at most one word and result_stall is low;
// bytes that make two or three words are paced by the single read port of the
// eight-entry result queue: byte_stall rises while more than five words wait.
// A stalled receiver holds the head word; the queue then fills and the byte
// channel stalls. Reset clears the parser to await a signature, empties the
// queue and sets the limits to 64 bands and 200000000 pixels per band.
// The config channel (cfg_index, cfg_data) is always ready; write only while
// idle. end_of_buffer rearms the parser after its own results.
`timescale 1ns / 1ps
`default_nettype none
module granule_container_stream_parser (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           byte_valid,
	output logic                                byte_stall,
	input  wire logic [7:0]                     data_byte,
	input  wire logic                           end_of_buffer,
	output logic                                result_valid,
	input  wire logic                           result_stall,
	output logic [2:0]                          item_type,
	output logic [4:0]                          field_id,
	output logic [15:0]                         band_index,
	output logic [63:0]                         field_value,
	output logic                                pixel_valid,
	output logic [2:0]                          error_code,
	output logic                                last_of_run,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [gcsp_pkg::CfgIndexW-1:0] cfg_index,
	input  wire logic [31:0]                    cfg_data
);

	typedef enum logic [2:0] {
		PH_SIG, PH_HDR, PH_BANDF, PH_STR, PH_PIX, PH_IDLE
	} phase_t;

	localparam int unsigned Aw = gcsp_pkg::QueueAw;
	localparam int unsigned Cw = Aw + 1;

	phase_t       phase_q, phase_n;
	logic [4:0]   field_step_q, field_step_n;
	logic [2:0]   bif_q, bif_n;
	logic [63:0]  shift_q, shift_n;
	logic [15:0]  bands_total_q, bands_total_n;
	logic [15:0]  band_cnt_q, band_cnt_n;
	logic [7:0]   str_left_q, str_left_n;
	logic [31:0]  width_q, width_n;
	logic [31:0]  pix_left_q, pix_left_n;
	logic [15:0]  fill_q, fill_n;
	logic [15:0]  cmin_q, cmin_n;
	logic [15:0]  cmax_q, cmax_n;
	logic         seen_q, seen_n;
	logic         vbad_q, vbad_n;
	logic [15:0]  max_bands_q;
	logic [31:0]  max_pix_q;

	gcsp_pkg::result_t res [gcsp_pkg::MaxResults];
	logic [1:0]        nres;

	gcsp_pkg::result_t qmem [gcsp_pkg::QueueDepth];
	logic [Aw-1:0]     wr_q, rd_q;
	logic [Cw-1:0]     cnt_q;

	logic push, pop;

	assign byte_stall   = (cnt_q > Cw'(gcsp_pkg::StallLevel));
	assign push         = byte_valid && !byte_stall;
	assign result_valid = (cnt_q != '0);
	assign pop          = result_valid && !result_stall;
	assign cfg_ready    = 1'b1;

	assign item_type   = qmem[rd_q].item_type;
	assign field_id    = qmem[rd_q].field_id;
	assign band_index  = qmem[rd_q].band_index;
	assign field_value = qmem[rd_q].field_value;
	assign pixel_valid = qmem[rd_q].pixel_valid;
	assign error_code  = qmem[rd_q].error_code;
	assign last_of_run = qmem[rd_q].last_of_run;

	always_comb begin
		logic [4:0]  step;
		logic [3:0]  size;
		logic [63:0] v;
		logic [7:0]  hid;
		logic [15:0] code;
		logic        pv;
		logic [63:0] prod;
		logic [31:0] h;
		phase_n       = phase_q;
		field_step_n  = field_step_q;
		bif_n         = bif_q;
		shift_n       = shift_q;
		bands_total_n = bands_total_q;
		band_cnt_n    = band_cnt_q;
		str_left_n    = str_left_q;
		width_n       = width_q;
		pix_left_n    = pix_left_q;
		fill_n        = fill_q;
		cmin_n        = cmin_q;
		cmax_n        = cmax_q;
		seen_n        = seen_q;
		vbad_n        = vbad_q;
		nres          = 2'd0;
		for (int i = 0; i < gcsp_pkg::MaxResults; i++) begin
			res[i] = gcsp_pkg::make_result('0, '0, '0, '0, 1'b0, '0);
		end
		step = '0;
		size = '0;
		v    = '0;
		hid  = '0;
		code = '0;
		pv   = 1'b0;
		h    = '0;
		prod = '0;

		unique case (phase_q)
			PH_SIG: begin
				if (data_byte != gcsp_pkg::sig_byte(bif_q[1:0])) begin
					res[nres] = gcsp_pkg::make_result(gcsp_pkg::IT_ERROR, '0, band_cnt_n, '0,
						1'b0, gcsp_pkg::ERR_SIGNATURE);
					nres    = nres + 2'd1;
					phase_n = PH_IDLE;
				end else if (bif_q == 3'd3) begin
					phase_n      = PH_HDR;
					field_step_n = '0;
					bif_n        = '0;
					shift_n      = '0;
				end else begin
					bif_n = bif_q + 3'd1;
				end
			end
			PH_HDR, PH_BANDF: begin
				step = field_step_q;
				if (phase_q == PH_HDR) begin
					if (step >= 5'(gcsp_pkg::HdrSteps)) step = 5'(gcsp_pkg::HdrSteps - 1);
					size = gcsp_pkg::hdr_size(step);
				end else begin
					if (step >= 5'(gcsp_pkg::BandSteps)) step = 5'(gcsp_pkg::BandSteps - 1);
					size = gcsp_pkg::band_size(step);
				end
				v = shift_q;
				v[8*bif_q +: 8] = data_byte;
				if ({1'b0, bif_q} + 4'd1 >= size) begin
					bif_n        = '0;
					shift_n      = '0;
					field_step_n = step + 5'd1;
					if (phase_q == PH_HDR) begin
						hid = gcsp_pkg::hdr_id(step);
						if (step == gcsp_pkg::HDR_STEP_VERSION) begin
							vbad_n = (v != 64'd1);
						end else if (step == gcsp_pkg::HDR_STEP_RESERVED) begin
							if (vbad_q) begin
								res[nres] = gcsp_pkg::make_result(gcsp_pkg::IT_ERROR, '0,
									band_cnt_n, '0, 1'b0, gcsp_pkg::ERR_VERSION);
								nres    = nres + 2'd1;
								phase_n = PH_IDLE;
							end
						end else begin
							if (hid != gcsp_pkg::NoField) begin
								res[nres] = gcsp_pkg::make_result(gcsp_pkg::IT_HEADER, hid[4:0],
									band_cnt_n, v, 1'b0, '0);
								nres = nres + 2'd1;
							end
							if (step == gcsp_pkg::HDR_STEP_BANDS) bands_total_n = v[15:0];
							if (step == gcsp_pkg::HDR_STEP_LAST) begin
								if (bands_total_q == '0 || bands_total_q > max_bands_q) begin
									res[nres] = gcsp_pkg::make_result(gcsp_pkg::IT_ERROR, '0,
										band_cnt_n, '0, 1'b0, gcsp_pkg::ERR_BAND_CNT);
									nres    = nres + 2'd1;
									phase_n = PH_IDLE;
								end else begin
									phase_n      = PH_BANDF;
									band_cnt_n   = '0;
									field_step_n = '0;
								end
							end
						end
					end else begin
						res[nres] = gcsp_pkg::make_result(gcsp_pkg::IT_BAND, step, band_cnt_n, v,
							1'b0, '0);
						nres = nres + 2'd1;
						if (step == gcsp_pkg::BAND_STEP_NAMELEN ||
								step == gcsp_pkg::BAND_STEP_UNITLEN) begin
							str_left_n = v[7:0];
							if (v[7:0] != '0) phase_n = PH_STR;
						end else if (step == gcsp_pkg::BAND_STEP_FILL) begin
							fill_n = v[15:0];
						end else if (step == gcsp_pkg::BAND_STEP_WIDTH) begin
							width_n = v[31:0];
						end else if (step == gcsp_pkg::BAND_STEP_HEIGHT) begin
							h    = v[31:0];
							prod = width_q * h;
							if (width_q[31] || width_q == '0 || h[31] || h == '0 ||
									prod > {32'd0, max_pix_q}) begin
								res[nres] = gcsp_pkg::make_result(gcsp_pkg::IT_ERROR, '0,
									band_cnt_n, '0, 1'b0, gcsp_pkg::ERR_DIMS);
								nres    = nres + 2'd1;
								phase_n = PH_IDLE;
							end else begin
								pix_left_n = prod[31:0];
								cmin_n     = 16'hFFFF;
								cmax_n     = '0;
								seen_n     = 1'b0;
								phase_n    = PH_PIX;
							end
						end
					end
				end else begin
					shift_n = v;
					bif_n   = bif_q + 3'd1;
				end
			end
			PH_STR: begin
				res[nres] = gcsp_pkg::make_result(gcsp_pkg::IT_STRING,
					(field_step_q == '0) ? 5'd0 : field_step_q - 5'd1, band_cnt_n,
					{56'd0, data_byte}, 1'b0, '0);
				nres       = nres + 2'd1;
				str_left_n = str_left_q - 8'd1;
				if (str_left_n == '0) phase_n = PH_BANDF;
			end
			PH_PIX: begin
				if (bif_q == '0) begin
					shift_n = {56'd0, data_byte};
					bif_n   = 3'd1;
				end else begin
					code    = {data_byte, shift_q[7:0]};
					pv      = (code != fill_q);
					bif_n   = '0;
					shift_n = '0;
					res[nres] = gcsp_pkg::make_result(gcsp_pkg::IT_PIXEL, '0, band_cnt_n,
						{48'd0, code}, pv, '0);
					nres = nres + 2'd1;
					if (pv) begin
						seen_n = 1'b1;
						if (code < cmin_q) cmin_n = code;
						if (code > cmax_q) cmax_n = code;
					end
					pix_left_n = pix_left_q - 32'd1;
					if (pix_left_n == '0) begin
						res[nres] = gcsp_pkg::make_result(gcsp_pkg::IT_RANGE, '0, band_cnt_n,
							seen_n ? {32'd0, cmax_n, cmin_n} : 64'd0, seen_n, '0);
						nres       = nres + 2'd1;
						band_cnt_n = band_cnt_q + 16'd1;
						if (band_cnt_n >= bands_total_q) begin
							res[nres] = gcsp_pkg::make_result(gcsp_pkg::IT_DONE, '0, band_cnt_n,
								'0, 1'b0, '0);
							nres    = nres + 2'd1;
							phase_n = PH_IDLE;
						end else begin
							phase_n      = PH_BANDF;
							field_step_n = '0;
						end
					end
				end
			end
			PH_IDLE: begin
			end
			default: begin
			end
		endcase

		if (end_of_buffer) begin
			if (phase_n != PH_IDLE) begin
				res[nres] = gcsp_pkg::make_result(gcsp_pkg::IT_ERROR, '0, band_cnt_n, '0, 1'b0,
					(phase_n == PH_SIG) ? gcsp_pkg::ERR_SIGNATURE :
					(phase_n == PH_HDR) ? ((field_step_n <= 5'd1) ? gcsp_pkg::ERR_SIGNATURE :
						gcsp_pkg::ERR_HDR_SHORT) :
					(phase_n == PH_PIX) ? gcsp_pkg::ERR_DATA_SHORT : gcsp_pkg::ERR_REC_SHORT);
				nres = nres + 2'd1;
			end
			phase_n       = PH_SIG;
			field_step_n  = '0;
			bif_n         = '0;
			shift_n       = '0;
			bands_total_n = '0;
			band_cnt_n    = '0;
			str_left_n    = '0;
			width_n       = '0;
			pix_left_n    = '0;
			fill_n        = '0;
			cmin_n        = 16'hFFFF;
			cmax_n        = '0;
			seen_n        = 1'b0;
			vbad_n        = 1'b0;
		end

		if (nres != 2'd0) res[nres - 2'd1].last_of_run = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_SIG;
			field_step_q  <= '0;
			bif_q         <= '0;
			shift_q       <= '0;
			bands_total_q <= '0;
			band_cnt_q    <= '0;
			str_left_q    <= '0;
			width_q       <= '0;
			pix_left_q    <= '0;
			fill_q        <= '0;
			cmin_q        <= 16'hFFFF;
			cmax_q        <= '0;
			seen_q        <= 1'b0;
			vbad_q        <= 1'b0;
		end else if (push) begin
			phase_q       <= phase_n;
			field_step_q  <= field_step_n;
			bif_q         <= bif_n;
			shift_q       <= shift_n;
			bands_total_q <= bands_total_n;
			band_cnt_q    <= band_cnt_n;
			str_left_q    <= str_left_n;
			width_q       <= width_n;
			pix_left_q    <= pix_left_n;
			fill_q        <= fill_n;
			cmin_q        <= cmin_n;
			cmax_q        <= cmax_n;
			seen_q        <= seen_n;
			vbad_q        <= vbad_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bands_q <= gcsp_pkg::MaxBandCountRst;
			max_pix_q   <= gcsp_pkg::MaxPixelsPerBandRst;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				gcsp_pkg::CFG_MAX_BAND_COUNT: max_bands_q <= cfg_data[15:0];
				gcsp_pkg::CFG_MAX_PIXELS:     max_pix_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// result queue: push all words of a byte at once, drain one per cycle while result_stall is low
	always_ff @(posedge clk) begin
		if (push) begin
			for (int i = 0; i < gcsp_pkg::MaxResults; i++) begin
				if (2'(i) < nres) qmem[wr_q + Aw'(i)] <= res[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + Aw'(nres);
			if (pop) rd_q <= rd_q + Aw'(1);
			cnt_q <= cnt_q + (push ? Cw'(nres) : Cw'(0)) - (pop ? Cw'(1) : Cw'(0));
		end
	end

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= Cw'(gcsp_pkg::QueueDepth))
		else $error("result queue overflow");

	a_range_order: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PIX && seen_q) |-> (cmin_q <= cmax_q))
		else $error("band range min above max");

	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		(push && end_of_buffer) |=> (phase_q == PH_SIG && field_step_q == '0 && bif_q == '0))
		else $error("parser not rearmed after end of buffer");

endmodule
`default_nettype wire
